@@ design/icr_pkg.sv @@
// shared constants and codes for the impulse collision response core
`timescale 1ns / 1ps
`default_nettype none

package icr_pkg;

  // word format of positions, velocities and masses
  localparam int W = 32;
  localparam int FRAC_BITS = 16;

  // impulse factor register, unsigned q1.8
  localparam int FACTOR_W = 9;
  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 9'd128;

  // pipeline step counts and the unit component width
  localparam int SQRT_STEPS = W;
  localparam int UDIV_STEPS = FRAC_BITS + 1;
  localparam int U_W = FRAC_BITS + 2;
  localparam int S1_BITS = 38;

  // result outcome codes
  localparam logic [1:0] OUT_APPLIED  = 2'd0;
  localparam logic [1:0] OUT_SEPARATE = 2'd1;
  localparam logic [1:0] OUT_DEGEN    = 2'd2;
  localparam logic [1:0] OUT_SAT      = 2'd3;

endpackage

`default_nettype wire

@@ design/icr_if.sv @@
// valid/ready channel interfaces for collision pairs and responses
`timescale 1ns / 1ps
`default_nettype none

interface icr_in_if import icr_pkg::*; ();
  logic valid;
  logic ready;
  logic [W-1:0] offset_x;
  logic [W-1:0] offset_y;
  logic [W-1:0] offset_z;
  logic [W-1:0] first_vel_x;
  logic [W-1:0] first_vel_y;
  logic [W-1:0] first_vel_z;
  logic [W-1:0] second_vel_x;
  logic [W-1:0] second_vel_y;
  logic [W-1:0] second_vel_z;
  logic [W-1:0] first_mass;
  logic [W-1:0] second_mass;

  modport source (
    output valid, offset_x, offset_y, offset_z, first_vel_x, first_vel_y, first_vel_z,
           second_vel_x, second_vel_y, second_vel_z, first_mass, second_mass,
    input ready
  );
  modport sink (
    input valid, offset_x, offset_y, offset_z, first_vel_x, first_vel_y, first_vel_z,
          second_vel_x, second_vel_y, second_vel_z, first_mass, second_mass,
    output ready
  );
endinterface

interface icr_out_if import icr_pkg::*; ();
  logic valid;
  logic ready;
  logic [W-1:0] new_first_vel_x;
  logic [W-1:0] new_first_vel_y;
  logic [W-1:0] new_first_vel_z;
  logic [W-1:0] new_second_vel_x;
  logic [W-1:0] new_second_vel_y;
  logic [W-1:0] new_second_vel_z;
  logic [1:0] outcome;

  modport source (
    output valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
           new_second_vel_x, new_second_vel_y, new_second_vel_z, outcome,
    input ready
  );
  modport sink (
    input valid, new_first_vel_x, new_first_vel_y, new_first_vel_z,
          new_second_vel_x, new_second_vel_y, new_second_vel_z, outcome,
    output ready
  );
endinterface

`default_nettype wire

@@ design/impulse_collision_response_core.sv @@
// impulse collision response core: deep pipeline from colliding pair to new velocities
// Usage:
//   pair_in carries one colliding pair per beat: offset from body one to body two,
//   both velocities and both masses, signed/unsigned q16.16. pair_out carries the
//   new velocities and a 2-bit outcome (applied, separating, degenerate, saturated).
//   cfg_we/cfg_wdata write the 9-bit impulse factor (q1.8); write it only while idle.
// Throughput: one pair per clock while pair_out is not held off. The work runs through
//   96 register stages: a 32-step square root, three 17-step quotient lanes for the
//   unit direction and a 38-step divider for the mass ratio, one result bit per
//   stage each.
// Stalls: the whole pipeline advances when the output register is empty or its beat
//   is taken; while pair_out is held off with a result waiting, pair_in.ready is low
//   and nothing is lost or repeated.
// Reset: rst (synchronous) empties the pipeline and sets the impulse factor to one
//   half (128).
`timescale 1ns / 1ps
`default_nettype none

module impulse_collision_response_core import icr_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [FACTOR_W-1:0] cfg_wdata,
  icr_in_if.sink                   pair_in,
  icr_out_if.source                pair_out
);

  // stage map
  localparam int ST_SUM   = 1;
  localparam int ST_SQRT0 = ST_SUM + 1;
  localparam int ST_UDIV0 = ST_SQRT0 + SQRT_STEPS;
  localparam int ST_PROD  = ST_UDIV0 + UDIV_STEPS;
  localparam int ST_DOT   = ST_PROD + 1;
  localparam int ST_P     = ST_DOT + 1;
  localparam int ST_PM    = ST_P + 1;
  localparam int ST_N     = ST_PM + 1;
  localparam int ST_QDIV0 = ST_N + 1;
  localparam int ST_E1    = ST_QDIV0 + S1_BITS;
  localparam int ST_OUT   = ST_E1 + 1;
  localparam int NSTAGE   = ST_OUT + 1;

  // datapath widths
  localparam int SQ_W   = 2 * W;
  localparam int SR_W   = W + 3;
  localparam int DIFF_W = W + 1;
  localparam int PROD_W = DIFF_W + U_W;
  localparam int DOT_W  = PROD_W + 2;
  localparam int VEL_W  = DOT_W - FRAC_BITS;
  localparam int C_W    = VEL_W - 1;
  localparam int P_W    = C_W + FACTOR_W;
  localparam int HALF_W = W / 2;
  localparam int PM_W   = P_W + HALF_W;
  localparam int N_W    = P_W + W;
  localparam int D_W    = W + 8;
  localparam int TOP_W  = N_W - S1_BITS;
  localparam int S2_W   = P_W - 8;
  localparam int PR1_W  = S1_BITS + 1 + U_W;
  localparam int PR2_W  = S2_W + 1 + U_W;
  localparam int DL_W   = PR1_W - FRAC_BITS;
  localparam int NV_W   = DL_W + 1;

  typedef struct packed {
    logic [2:0][W-1:0]   v1;
    logic [2:0][W-1:0]   v2;
    logic [W-1:0]        m1;
    logic [W-1:0]        m2;
    logic [2:0][W-1:0]   ad;
    logic [2:0]          neg;
    logic [2:0][U_W-1:0] u;
    logic                sep;
    logic [S2_W-1:0]     s2;
    logic                degen;
  } side_t;

  logic                en;
  logic [NSTAGE-1:0]   vld;
  logic [FACTOR_W-1:0] factor_q;

  side_t side_q [ST_E1+1];
  side_t side_d [ST_E1+1];
  side_t fresh;

  // pipeline moves when the output register is free or being emptied
  assign en = !vld[ST_OUT] || pair_out.ready;
  assign pair_in.ready = en;
  assign pair_out.valid = vld[ST_OUT];

  // impulse factor register
  always_ff @(posedge clk) begin
    if (rst) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_we) begin
      factor_q <= cfg_wdata;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], pair_in.valid};
    end
  end

  // entry: absolute offsets, squares and degenerate check
  logic [2:0][W-1:0] din;
  logic [SQ_W-1:0]   sq_d [3];
  logic [SQ_W-1:0]   sq_q [3];
  logic [SQ_W-1:0]   sum_q;

  assign din[0] = pair_in.offset_x;
  assign din[1] = pair_in.offset_y;
  assign din[2] = pair_in.offset_z;

  always_comb begin
    fresh = '0;
    fresh.v1[0] = pair_in.first_vel_x;
    fresh.v1[1] = pair_in.first_vel_y;
    fresh.v1[2] = pair_in.first_vel_z;
    fresh.v2[0] = pair_in.second_vel_x;
    fresh.v2[1] = pair_in.second_vel_y;
    fresh.v2[2] = pair_in.second_vel_z;
    fresh.m1 = pair_in.first_mass;
    fresh.m2 = pair_in.second_mass;
    for (int i = 0; i < 3; i++) begin
      fresh.neg[i] = din[i][W-1];
      fresh.ad[i] = din[i][W-1] ? (W'(0) - din[i]) : din[i];
      sq_d[i] = SQ_W'(fresh.ad[i]) * SQ_W'(fresh.ad[i]);
    end
    fresh.degen = (din == '0) || (pair_in.first_mass == '0) || (pair_in.second_mass == '0);
  end

  // square root: one root bit per stage
  logic [SQ_W-1:0] sx_q [SQRT_STEPS];
  logic [SR_W-1:0] sr_q [SQRT_STEPS];
  logic [W-1:0]    sroot_q [SQRT_STEPS];

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    logic [SQ_W-1:0] x_in;
    logic [SR_W-1:0] r_in;
    logic [W-1:0]    q_in;
    logic [SR_W-1:0] t;
    logic [SR_W-1:0] trial;
    logic            ge;
    if (k == 0) begin : g_first
      assign x_in = sum_q;
      assign r_in = '0;
      assign q_in = '0;
    end else begin : g_next
      assign x_in = sx_q[k-1];
      assign r_in = sr_q[k-1];
      assign q_in = sroot_q[k-1];
    end
    assign t = {r_in[SR_W-3:0], x_in[SQ_W-1:SQ_W-2]};
    assign trial = {1'b0, q_in, 2'b01};
    assign ge = t >= trial;
    always_ff @(posedge clk) begin
      if (en) begin
        sx_q[k] <= {x_in[SQ_W-3:0], 2'b00};
        sr_q[k] <= ge ? (t - trial) : t;
        sroot_q[k] <= {q_in[W-2:0], ge};
      end
    end
  end

  // unit direction: three quotient lanes, one bit per stage
  logic [W-1:0]          umag_q [UDIV_STEPS];
  logic [W-1:0]          ur_q [3][UDIV_STEPS];
  logic [UDIV_STEPS-1:0] un_q [3][UDIV_STEPS];
  logic [UDIV_STEPS-1:0] uq_q [3][UDIV_STEPS];

  for (genvar j = 0; j < UDIV_STEPS; j++) begin : g_umag
    logic [W-1:0] m_in;
    if (j == 0) begin : g_first
      assign m_in = sroot_q[SQRT_STEPS-1];
    end else begin : g_next
      assign m_in = umag_q[j-1];
    end
    always_ff @(posedge clk) begin
      if (en) begin
        umag_q[j] <= m_in;
      end
    end
  end

  for (genvar l = 0; l < 3; l++) begin : g_lane
    for (genvar j = 0; j < UDIV_STEPS; j++) begin : g_step
      logic [W-1:0]          r_in;
      logic [UDIV_STEPS-1:0] n_in;
      logic [UDIV_STEPS-1:0] q_in;
      logic [W-1:0]          m_in;
      logic [W:0]            t;
      logic [W:0]            sub;
      logic                  ge;
      if (j == 0) begin : g_first
        assign r_in = {1'b0, side_q[ST_UDIV0-1].ad[l][W-1:1]};
        assign n_in = {side_q[ST_UDIV0-1].ad[l][0], {FRAC_BITS{1'b0}}};
        assign q_in = '0;
        assign m_in = sroot_q[SQRT_STEPS-1];
      end else begin : g_next
        assign r_in = ur_q[l][j-1];
        assign n_in = un_q[l][j-1];
        assign q_in = uq_q[l][j-1];
        assign m_in = umag_q[j-1];
      end
      assign t = {r_in, n_in[UDIV_STEPS-1]};
      assign sub = t - {1'b0, m_in};
      assign ge = t >= {1'b0, m_in};
      always_ff @(posedge clk) begin
        if (en) begin
          ur_q[l][j] <= ge ? sub[W-1:0] : t[W-1:0];
          un_q[l][j] <= {n_in[UDIV_STEPS-2:0], 1'b0};
          uq_q[l][j] <= {q_in[UDIV_STEPS-2:0], ge};
        end
      end
    end
  end

  // signed unit components and closing-speed products
  logic [2:0][U_W-1:0]       u_new;
  logic signed [PROD_W-1:0]  prod_d [3];
  logic signed [PROD_W-1:0]  prod_q [3];
  logic signed [DOT_W-1:0]   dot_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_new[i] = side_q[ST_PROD-1].neg[i]
               ? (U_W'(0) - {1'b0, uq_q[i][UDIV_STEPS-1]})
               : {1'b0, uq_q[i][UDIV_STEPS-1]};
      prod_d[i] = ($signed({side_q[ST_PROD-1].v2[i][W-1], side_q[ST_PROD-1].v2[i]})
                 - $signed({side_q[ST_PROD-1].v1[i][W-1], side_q[ST_PROD-1].v1[i]}))
                 * $signed(u_new[i]);
    end
  end

  // relative speed, impulse magnitude
  logic signed [VEL_W-1:0] vel;
  logic [C_W-1:0]          cspd;
  logic                    sep_new;
  logic [P_W-1:0]          p_d;
  logic [P_W-1:0]          p_q;
  logic [PM_W-1:0]         pmh_q;
  logic [PM_W-1:0]         pml_q;

  assign vel = dot_q[DOT_W-1:FRAC_BITS];
  assign sep_new = !vel[VEL_W-1] && (vel != '0);
  always_comb begin
    cspd = C_W'(VEL_W'(0) - vel);
    p_d = P_W'(cspd) * P_W'(factor_q);
  end

  // side chain
  always_comb begin
    side_d[0] = fresh;
    for (int k = 1; k <= ST_E1; k++) begin
      side_d[k] = side_q[k-1];
    end
    side_d[ST_PROD].u = u_new;
    side_d[ST_P].sep = sep_new;
    side_d[ST_PM].s2 = p_q[P_W-1:8];
  end

  // mass-ratio divider entry
  logic [N_W-1:0]   nfull;
  logic [TOP_W-1:0] ntop;
  logic [D_W-1:0]   dn;
  logic             ovf_new;

  assign nfull = (N_W'(pmh_q) << HALF_W) + N_W'(pml_q);
  assign ntop = nfull[N_W-1:S1_BITS];
  assign dn = {side_q[ST_N-1].m1, 8'd0};
  assign ovf_new = N_W'(ntop) >= N_W'(dn);

  // front section registers
  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k <= ST_E1; k++) begin
        side_q[k] <= side_d[k];
      end
      for (int i = 0; i < 3; i++) begin
        sq_q[i] <= sq_d[i];
        prod_q[i] <= prod_d[i];
      end
      sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
      dot_q <= DOT_W'(prod_q[0]) + DOT_W'(prod_q[1]) + DOT_W'(prod_q[2]);
      p_q <= p_d;
      pmh_q <= PM_W'(p_q) * PM_W'(side_q[ST_PM-1].m2[W-1:HALF_W]);
      pml_q <= PM_W'(p_q) * PM_W'(side_q[ST_PM-1].m2[HALF_W-1:0]);
    end
  end

  // mass-ratio divider: one quotient bit per stage
  logic [D_W-1:0]     qr_q [S1_BITS+1];
  logic [S1_BITS-1:0] qn_q [S1_BITS+1];
  logic [S1_BITS-1:0] qq_q [S1_BITS+1];
  logic               qovf_q [S1_BITS+1];

  always_ff @(posedge clk) begin
    if (en) begin
      qr_q[0] <= ovf_new ? '0 : D_W'(ntop);
      qn_q[0] <= nfull[S1_BITS-1:0];
      qq_q[0] <= '0;
      qovf_q[0] <= ovf_new;
    end
  end

  for (genvar j = 1; j <= S1_BITS; j++) begin : g_qdiv
    logic [D_W:0]   t;
    logic [D_W:0]   sub;
    logic [D_W-1:0] dv;
    logic           ge;
    assign dv = {side_q[ST_QDIV0+j-2].m1, 8'd0};
    assign t = {qr_q[j-1], qn_q[j-1][S1_BITS-1]};
    assign sub = t - {1'b0, dv};
    assign ge = t >= {1'b0, dv};
    always_ff @(posedge clk) begin
      if (en) begin
        qr_q[j] <= ge ? sub[D_W-1:0] : t[D_W-1:0];
        qn_q[j] <= {qn_q[j-1][S1_BITS-2:0], 1'b0};
        qq_q[j] <= {qq_q[j-1][S1_BITS-2:0], ge};
        qovf_q[j] <= qovf_q[j-1];
      end
    end
  end

  // velocity change products
  logic [S1_BITS-1:0]       s1;
  logic signed [PR1_W-1:0]  pr1_d [3];
  logic signed [PR2_W-1:0]  pr2_d [3];
  logic signed [PR1_W-1:0]  pr1_q [3];
  logic signed [PR2_W-1:0]  pr2_q [3];
  logic                     e_sat_q;

  assign s1 = qovf_q[S1_BITS] ? '1 : qq_q[S1_BITS];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pr1_d[i] = $signed({1'b0, s1}) * $signed(side_q[ST_E1-1].u[i]);
      pr2_d[i] = $signed({1'b0, side_q[ST_E1-1].s2}) * $signed(side_q[ST_E1-1].u[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr1_q[i] <= pr1_d[i];
        pr2_q[i] <= pr2_d[i];
      end
      e_sat_q <= qovf_q[S1_BITS];
    end
  end

  // final add, saturation and outcome
  logic [2:0][W-1:0] nv1;
  logic [2:0][W-1:0] nv2;
  logic [5:0]        satv;

  for (genvar i = 0; i < 3; i++) begin : g_fin
    logic signed [NV_W-1:0] n1;
    logic signed [NV_W-1:0] n2;
    logic                   hi1;
    logic                   lo1;
    logic                   hi2;
    logic                   lo2;
    assign n1 = NV_W'($signed(side_q[ST_E1].v1[i]))
              - NV_W'($signed(pr1_q[i][PR1_W-1:FRAC_BITS]));
    assign n2 = NV_W'($signed(side_q[ST_E1].v2[i]))
              + NV_W'($signed(pr2_q[i][PR2_W-1:FRAC_BITS]));
    assign hi1 = !n1[NV_W-1] && (n1[NV_W-2:W-1] != '0);
    assign lo1 = n1[NV_W-1] && (n1[NV_W-2:W-1] != '1);
    assign hi2 = !n2[NV_W-1] && (n2[NV_W-2:W-1] != '0);
    assign lo2 = n2[NV_W-1] && (n2[NV_W-2:W-1] != '1);
    assign nv1[i] = hi1 ? {1'b0, {(W-1){1'b1}}} : lo1 ? {1'b1, {(W-1){1'b0}}} : n1[W-1:0];
    assign nv2[i] = hi2 ? {1'b0, {(W-1){1'b1}}} : lo2 ? {1'b1, {(W-1){1'b0}}} : n2[W-1:0];
    assign satv[2*i] = hi1 || lo1;
    assign satv[2*i+1] = hi2 || lo2;
  end

  logic [2:0][W-1:0] o1_d;
  logic [2:0][W-1:0] o2_d;
  logic [1:0]        oc_d;
  logic [2:0][W-1:0] o1_q;
  logic [2:0][W-1:0] o2_q;
  logic [1:0]        oc_q;

  always_comb begin
    priority if (side_q[ST_E1].degen) begin
      o1_d = side_q[ST_E1].v1;
      o2_d = side_q[ST_E1].v2;
      oc_d = OUT_DEGEN;
    end else if (side_q[ST_E1].sep) begin
      o1_d = side_q[ST_E1].v1;
      o2_d = side_q[ST_E1].v2;
      oc_d = OUT_SEPARATE;
    end else begin
      o1_d = nv1;
      o2_d = nv2;
      oc_d = (e_sat_q || (satv != '0)) ? OUT_SAT : OUT_APPLIED;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (en) begin
      o1_q <= o1_d;
      o2_q <= o2_d;
      oc_q <= oc_d;
    end
  end

  assign pair_out.new_first_vel_x  = o1_q[0];
  assign pair_out.new_first_vel_y  = o1_q[1];
  assign pair_out.new_first_vel_z  = o1_q[2];
  assign pair_out.new_second_vel_x = o2_q[0];
  assign pair_out.new_second_vel_y = o2_q[1];
  assign pair_out.new_second_vel_z = o2_q[2];
  assign pair_out.outcome          = oc_q;

endmodule

`default_nettype wire
